>>> src/jsu_pkg.sv
// package for the json string unescape unit: constants, result type and helper functions
package jsu_pkg;

  localparam int MAX_CAPACITY = 4096;
  localparam int CAP_W        = 13;
  localparam int LEN_W        = 12;
  localparam int NRES         = 4;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_HEX0   = 3'd2;
  localparam logic [2:0] MODE_HEX1   = 3'd3;
  localparam logic [2:0] MODE_HEX2   = 3'd4;
  localparam logic [2:0] MODE_HEX3   = 3'd5;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_END_OK  = 2'd1;
  localparam logic [1:0] KIND_END_OVF = 2'd2;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U      = 8'h75;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [2:0]             count;
    logic [3:0][7:0]        data;
    logic [3:0][1:0]        kind;
    logic [3:0][LEN_W-1:0]  len;
  } result_set_t;

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] h);
    logic [3:0] r;
    if (h >= 8'h30 && h <= 8'h39) r = 4'(h - 8'h30);
    else if (h >= 8'h61 && h <= 8'h66) r = 4'(h - 8'h57);
    else if (h >= 8'h41 && h <= 8'h46) r = 4'(h - 8'h37);
    else r = 4'd0;
    return r;
  endfunction

endpackage

>>> src/json_string_unescape_unit.sv
// top level of the json string unescape unit: stream ports, capacity register, result buffer
//
//  channel  | group                          | transaction
//  ---------+--------------------------------+------------------------------------------
//  input    | s_tvalid s_tready s_tdata ...  | one source byte, tlast ends the string
//  output   | m_tvalid m_tready m_tdata ...  | one unescaped byte or the end status
//  config   | psel penable pwrite paddr ...  | capacity register at address 0
//
//  an input transaction is decoded in the cycle it is accepted and yields 0 to 4 results
//  results drain one per cycle from a buffer while m_tready is high; a multi-result item
//  holds s_tready low until its last is taken, so single-result items flow at one per cycle
//  s_tready stays high while the buffer's final result is taken in the same cycle
//  synchronous reset clears the decode state and empties the buffer; capacity resets to 256
module json_string_unescape_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  input  logic        s_tuser,   // [0] in_empty
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [19:8] out_length, [23:20] zero
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // [1:0] out_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [jsu_pkg::CAP_W-1:0] capacity;
  logic [jsu_pkg::CAP_W-1:0] cap_clamped;
  logic [jsu_pkg::LEN_W-1:0] limit;
  jsu_pkg::result_set_t      res;
  jsu_pkg::result_set_t      rs;
  logic [2:0]                rem;
  logic [1:0]                idx;
  logic                      s_accept;
  logic                      m_accept;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr == {jsu_pkg::REG_CAPACITY, 2'b00});
  assign prdata  = reg_sel ? {{(32 - jsu_pkg::CAP_W){1'b0}}, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= jsu_pkg::CAP_W'(256);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity <= pwdata[jsu_pkg::CAP_W-1:0];
    end
  end

  assign cap_clamped = (capacity > jsu_pkg::CAP_W'(jsu_pkg::MAX_CAPACITY))
                       ? jsu_pkg::CAP_W'(jsu_pkg::MAX_CAPACITY) : capacity;
  assign limit = (capacity == '0) ? '0
                 : jsu_pkg::LEN_W'(cap_clamped - jsu_pkg::CAP_W'(1));

  assign m_tvalid = (rem != 3'd0);
  assign m_accept = m_tvalid && m_tready;
  assign s_tready = (rem == 3'd0) || (rem == 3'd1 && m_tready);
  assign s_accept = s_tvalid && s_tready;

  jsu_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (s_accept),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .in_empty (s_tuser),
    .limit    (limit),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
      idx <= 2'd0;
    end else if (s_accept) begin
      rem <= res.count;
      idx <= 2'd0;
    end else if (m_accept) begin
      rem <= rem - 3'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      rs <= res;
    end
  end

  assign m_tdata = {4'd0, rs.len[idx], rs.data[idx]};
  assign m_tuser = rs.kind[idx];
  assign m_tlast = (rem == 3'd1);

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != jsu_pkg::KIND_DATA |-> m_tlast)
    else $error("end status not the final result of its transaction");

  a_data_no_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == jsu_pkg::KIND_DATA |-> m_tdata[23:8] == 16'd0)
    else $error("length set on a data result");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= 3'd4 && (s_tready || m_tvalid))
    else $error("result buffer count out of range");

endmodule

>>> src/jsu_core.sv
// decode state and single-pass step logic of the json string unescape unit
module jsu_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                in_byte,
  input  logic                      in_last,
  input  logic                      in_empty,
  input  logic [jsu_pkg::LEN_W-1:0] limit,
  output jsu_pkg::result_set_t      res
);

  logic [2:0]                mode, mode_next;
  logic [15:0]               code_point, code_point_next;
  logic [7:0]                held [3];
  logic [7:0]                held_next [3];
  logic [jsu_pkg::LEN_W-1:0] written_count, written_count_next;
  logic                      overflowed, overflowed_next;
  logic                      fin;

  always_comb begin
    logic [2:0]  n;
    logic [2:0]  k;
    logic [2:0]  cnt;
    logic [1:0]  need;
    logic [15:0] u;
    logic        stop;
    logic        skip;
    logic [7:0]  hx [4];
    mode_next          = mode;
    code_point_next    = code_point;
    held_next          = held;
    written_count_next = written_count;
    overflowed_next    = overflowed;
    res                = '0;
    n                  = 3'd0;
    k                  = 3'd0;
    cnt                = 3'd0;
    need               = 2'd1;
    u                  = 16'd0;
    stop               = 1'b0;
    skip               = 1'b0;
    fin                = in_last || in_empty;

    if (!in_empty && !overflowed_next) begin
      unique case (mode)
        jsu_pkg::MODE_NORMAL: begin
          if (written_count_next >= limit) begin
            overflowed_next = 1'b1;
          end else if (in_byte != jsu_pkg::CHAR_BSLASH) begin
            res.data[n[1:0]] = in_byte;
            n = n + 3'd1;
            written_count_next = written_count_next + jsu_pkg::LEN_W'(1);
          end else begin
            mode_next = jsu_pkg::MODE_ESC;
          end
        end
        jsu_pkg::MODE_ESC: begin
          if (in_byte == jsu_pkg::CHAR_U) begin
            mode_next       = jsu_pkg::MODE_HEX0;
            code_point_next = 16'd0;
          end else begin
            res.data[n[1:0]] = jsu_pkg::esc_map(in_byte);
            n = n + 3'd1;
            written_count_next = written_count_next + jsu_pkg::LEN_W'(1);
            mode_next = jsu_pkg::MODE_NORMAL;
          end
        end
        default: begin
          k = mode - jsu_pkg::MODE_HEX0;
          code_point_next = {code_point[11:0], jsu_pkg::hex_val(in_byte)};
          if (k < 3'd3) begin
            held_next[k[1:0]] = in_byte;
            mode_next = mode + 3'd1;
          end else begin
            u = code_point_next;
            need = (u < 16'h0080) ? 2'd1 : ((u < 16'h0800) ? 2'd2 : 2'd3);
            mode_next = jsu_pkg::MODE_NORMAL;
            if ({1'b0, written_count_next} + {11'd0, need} > {1'b0, limit}) begin
              overflowed_next = 1'b1;
            end else begin
              unique case (need)
                2'd1: res.data[0] = u[7:0];
                2'd2: begin
                  res.data[0] = 8'hC0 | {3'd0, u[10:6]};
                  res.data[1] = 8'h80 | {2'd0, u[5:0]};
                end
                default: begin
                  res.data[0] = 8'hE0 | {4'd0, u[15:12]};
                  res.data[1] = 8'h80 | {2'd0, u[11:6]};
                  res.data[2] = 8'h80 | {2'd0, u[5:0]};
                end
              endcase
              n = {1'b0, need};
              written_count_next = written_count_next + jsu_pkg::LEN_W'(need);
            end
          end
        end
      endcase
    end

    // replay of a short unicode escape at the end of the string
    hx[0] = held_next[0];
    hx[1] = held_next[1];
    hx[2] = held_next[2];
    hx[3] = 8'd0;
    if (fin && !overflowed_next && mode_next >= jsu_pkg::MODE_HEX1
        && mode_next <= jsu_pkg::MODE_HEX3) begin
      cnt = mode_next - jsu_pkg::MODE_HEX0;
      for (int i = 0; i < 3; i++) begin
        if (skip) begin
          skip = 1'b0;
        end else if (3'(i) < cnt && !stop) begin
          if (written_count_next >= limit) begin
            overflowed_next = 1'b1;
            stop = 1'b1;
          end else if (hx[2'(i)] != jsu_pkg::CHAR_BSLASH) begin
            res.data[n[1:0]] = hx[2'(i)];
            n = n + 3'd1;
            written_count_next = written_count_next + jsu_pkg::LEN_W'(1);
          end else if (3'(i + 1) >= cnt) begin
            stop = 1'b1;
          end else begin
            skip = 1'b1;
            if (hx[2'(i + 1)] != jsu_pkg::CHAR_U) begin
              res.data[n[1:0]] = jsu_pkg::esc_map(hx[2'(i + 1)]);
              n = n + 3'd1;
              written_count_next = written_count_next + jsu_pkg::LEN_W'(1);
            end
          end
        end
      end
    end

    if (fin) begin
      res.kind[n[1:0]] = overflowed_next ? jsu_pkg::KIND_END_OVF : jsu_pkg::KIND_END_OK;
      res.len[n[1:0]]  = overflowed_next ? '0 : written_count_next;
      n = n + 3'd1;
      mode_next          = jsu_pkg::MODE_NORMAL;
      code_point_next    = 16'd0;
      written_count_next = '0;
      overflowed_next    = 1'b0;
    end
    res.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= jsu_pkg::MODE_NORMAL;
      code_point    <= 16'd0;
      written_count <= '0;
      overflowed    <= 1'b0;
    end else if (step) begin
      mode          <= mode_next;
      code_point    <= code_point_next;
      written_count <= written_count_next;
      overflowed    <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held <= held_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && fin |=> mode == jsu_pkg::MODE_NORMAL && written_count == '0 && !overflowed)
    else $error("state not cleared after end of string");

  a_ovf_no_data: assert property (@(posedge clk) disable iff (rst)
    step && overflowed |-> res.count <= 3'd1)
    else $error("data produced while overflowed");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    mode <= jsu_pkg::MODE_HEX3)
    else $error("decode mode out of range");

endmodule

>>> tb/tb_json_string_unescape_unit.sv
// testbench for json_string_unescape_unit: directed and random string bodies checked against a predictor
module tb_json_string_unescape_unit;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PHASE_CHARS    = 22;
  localparam logic [2:0] CAPACITY_ADDR = 3'(jsu_pkg::REG_CAPACITY) << 2;

  typedef struct packed {
    logic [7:0]               data;
    logic [1:0]               kind;
    logic [jsu_pkg::LEN_W-1:0] length;
    logic                     last;
  } unescaped_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } src_char_t;

  class unescape_scoreboard;
    logic [jsu_pkg::CAP_W-1:0] capacity;
    logic [2:0]       mode;
    logic [15:0]      code_point;
    logic [7:0]       held [3];
    int               written;
    bit               overflow;
    unescaped_t       step_out [$];
    unescaped_t       pending [$];
    int errors, inputs_seen, results_seen, overflow_ends, strings_done;

    function new();
      capacity = 13'd256;
      mode = jsu_pkg::MODE_NORMAL;
      code_point = '0;
      for (int i = 0; i < 3; i++) held[i] = '0;
      written = 0;
      overflow = 0;
      errors = 0;
      inputs_seen = 0;
      results_seen = 0;
      overflow_ends = 0;
      strings_done = 0;
    endfunction

    function int limit();
      int c;
      c = (int'(capacity) > jsu_pkg::MAX_CAPACITY) ? jsu_pkg::MAX_CAPACITY : int'(capacity);
      return (c == 0) ? 0 : c - 1;
    endfunction

    function void push_result(input logic [7:0] data, input logic [1:0] kind,
                              input logic [jsu_pkg::LEN_W-1:0] length);
      step_out.push_back('{data, kind, length, 1'b0});
    endfunction

    function void emit_byte(input logic [7:0] b);
      push_result(b, jsu_pkg::KIND_DATA, '0);
      written++;
    endfunction

    function logic [7:0] escape_char(input logic [7:0] c);
      case (c)
        "n":     return 8'h0A;
        "r":     return 8'h0D;
        "t":     return 8'h09;
        "b":     return 8'h08;
        "f":     return 8'h0C;
        default: return c;
      endcase
    endfunction

    function logic [3:0] hex_digit(input logic [7:0] h);
      if (h >= "0" && h <= "9") return 4'(h - "0");
      if (h >= "a" && h <= "f") return 4'(h - "a" + 8'd10);
      if (h >= "A" && h <= "F") return 4'(h - "A" + 8'd10);
      return 4'd0;
    endfunction

    function void decode_char(input logic [7:0] c);
      int k;
      int need;
      logic [15:0] u;
      if (overflow) return;
      if (mode == jsu_pkg::MODE_NORMAL) begin
        if (written >= limit()) overflow = 1;
        else if (c == jsu_pkg::CHAR_BSLASH) mode = jsu_pkg::MODE_ESC;
        else emit_byte(c);
      end else if (mode == jsu_pkg::MODE_ESC) begin
        if (c == jsu_pkg::CHAR_U) begin
          mode = jsu_pkg::MODE_HEX0;
          code_point = '0;
        end else begin
          emit_byte(escape_char(c));
          mode = jsu_pkg::MODE_NORMAL;
        end
      end else begin
        k = int'(mode) - int'(jsu_pkg::MODE_HEX0);
        code_point = {code_point[11:0], hex_digit(c)};
        if (k < 3) begin
          held[k] = c;
          mode = mode + 3'd1;
        end else begin
          u = code_point;
          need = (u < 16'h0080) ? 1 : (u < 16'h0800) ? 2 : 3;
          mode = jsu_pkg::MODE_NORMAL;
          if (written + need > limit()) begin
            overflow = 1;
          end else if (need == 1) begin
            emit_byte(u[7:0]);
          end else if (need == 2) begin
            emit_byte(8'hC0 | 8'(u >> 6));
            emit_byte(8'h80 | {2'b00, u[5:0]});
          end else begin
            emit_byte(8'hE0 | 8'(u >> 12));
            emit_byte(8'h80 | {2'b00, u[11:6]});
            emit_byte(8'h80 | {2'b00, u[5:0]});
          end
        end
      end
    endfunction

    // characters held after a cut-short \u go through the plain rules once more
    function void replay_held(input int cnt);
      int i;
      logic [7:0] c;
      i = 0;
      while (i < cnt) begin
        if (written >= limit()) begin
          overflow = 1;
          return;
        end
        c = held[i];
        i++;
        if (c != jsu_pkg::CHAR_BSLASH) begin
          emit_byte(c);
          continue;
        end
        if (i >= cnt) break;
        c = held[i];
        i++;
        if (c != jsu_pkg::CHAR_U) emit_byte(escape_char(c));
      end
    endfunction

    function void end_string();
      if (!overflow && mode >= jsu_pkg::MODE_HEX1 && mode <= jsu_pkg::MODE_HEX3)
        replay_held(int'(mode) - int'(jsu_pkg::MODE_HEX0));
      if (overflow) begin
        push_result('0, jsu_pkg::KIND_END_OVF, '0);
        overflow_ends++;
      end else begin
        push_result('0, jsu_pkg::KIND_END_OK, jsu_pkg::LEN_W'(written));
      end
      mode = jsu_pkg::MODE_NORMAL;
      code_point = '0;
      written = 0;
      overflow = 0;
      strings_done++;
    endfunction

    function void note_input(input logic [7:0] ch, input logic last, input logic empty);
      unescaped_t r;
      step_out.delete();
      inputs_seen++;
      if (!empty) decode_char(ch);
      if (last || empty) end_string();
      if (step_out.size() > 0) begin
        r = step_out.pop_back();
        r.last = 1'b1;
        step_out.push_back(r);
      end
      foreach (step_out[i]) pending.push_back(step_out[i]);
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(input logic [7:0] data, input logic [1:0] kind,
                      input logic [jsu_pkg::LEN_W-1:0] length, input logic last);
      unescaped_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h length %0d", kind, data, length));
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind)
        report($sformatf("result %0d kind %0d, expected %0d", results_seen, kind, want.kind));
      if (data !== want.data)
        report($sformatf("result %0d byte %02h, expected %02h", results_seen, data, want.data));
      if (length !== want.length)
        report($sformatf("result %0d length %0d, expected %0d", results_seen, length,
                         want.length));
      if (last !== want.last)
        report($sformatf("result %0d last %0b, expected %0b", results_seen, last, want.last));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;
  logic              m_tlast;
  logic [1:0]        m_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int send_idle = 23;
  int recv_idle = 88;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int settings_used = 0;
  src_char_t text [$];
  unescape_scoreboard sb = new();

  json_string_unescape_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tlast, s_tuser);
      if (m_tvalid && m_tready) sb.check_result(m_tdata[7:0], m_tuser, m_tdata[19:8], m_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, sb.pending.size());
      $display("tb_json_string_unescape_unit: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_char(input src_char_t c);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c.ch;
    s_tlast  <= c.last;
    s_tuser  <= c.empty;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_text(input int pause_at);
    foreach (text[i]) begin
      if (i == pause_at) wait_drained();
      send_char(text[i]);
    end
    text.delete();
  endtask

  task automatic write_capacity(input logic [jsu_pkg::CAP_W-1:0] value);
    wait_drained();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.capacity = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  function automatic void add_char(input logic [7:0] ch);
    text.push_back('{ch, 1'b0, 1'b0});
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void close_text();
    src_char_t r;
    r = text.pop_back();
    r.last = 1'b1;
    text.push_back(r);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + 8'(nib);
    if ($urandom_range(1)) return "A" + 8'(nib) - 8'd10;
    return "a" + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(9))
      0:       return "n";
      1:       return "r";
      2:       return "t";
      3:       return "b";
      4:       return "f";
      5:       return "\"";
      6:       return "\\";
      7:       return "/";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_hex_escape();
    logic [15:0] u;
    case ($urandom_range(3))
      0:       u = 16'($urandom_range(16'h007F));
      1:       u = 16'($urandom_range(16'h07FF, 16'h0080));
      2:       u = 16'($urandom_range(16'hFFFF, 16'h0800));
      default: u = 16'($urandom);
    endcase
    add_char(jsu_pkg::CHAR_BSLASH);
    add_char(jsu_pkg::CHAR_U);
    for (int i = 3; i >= 0; i--) begin
      if ($urandom_range(15) == 0) add_char("g" + 8'($urandom_range(19)));
      else add_char(hex_char(u[4*i +: 4]));
    end
  endfunction

  function automatic logic [7:0] pick_held_char();
    case ($urandom_range(7))
      0, 1:    return jsu_pkg::CHAR_BSLASH;
      2:       return jsu_pkg::CHAR_U;
      3:       return pick_escape();
      4, 5:    return hex_char(4'($urandom));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void build_string(input int units);
    int pick;
    int held_n;
    for (int i = 0; i < units; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        add_char(8'($urandom_range(255)));
      end else if (pick < 75) begin
        add_char(jsu_pkg::CHAR_BSLASH);
        add_char(pick_escape());
      end else begin
        add_hex_escape();
      end
    end
    pick = $urandom_range(99);
    if (pick < 12) begin
      text.push_back('{8'($urandom), 1'($urandom), 1'b1});
      return;
    end
    if (pick < 27) begin
      add_char(jsu_pkg::CHAR_BSLASH);
      add_char(jsu_pkg::CHAR_U);
      held_n = $urandom_range(3);
      for (int j = 0; j < held_n; j++) add_char(pick_held_char());
    end else if (pick < 34) begin
      add_char(jsu_pkg::CHAR_BSLASH);
    end else if (text.size() == 0) begin
      add_char(8'($urandom_range(255)));
    end
    close_text();
  endfunction

  initial begin
    logic [jsu_pkg::CAP_W-1:0] caps [8];
    int phase_items;
    int pause_at;
    caps = '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd6, 13'd13, 13'd4097, 13'd2};
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed strings at the reset capacity
    add_char(8'h00);
    add_str("\\n\\u07Ff\\q");
    add_char(8'hFF);
    close_text();
    add_str("\\uE2g2\\");
    close_text();
    add_str("\\u\\u");
    close_text();
    text.push_back('{8'h00, 1'b1, 1'b1});
    text.push_back('{"x", 1'b0, 1'b1});
    send_text(-1);

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle = 88;
        recv_idle = 23;
      end
      if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_capacity(p == 7 ? 13'($urandom_range(40, 2)) : caps[p]);
      phase_items = 0;
      while (phase_items < PHASE_CHARS) begin
        pause_at = -1;
        if (p == 6 && phase_items == 0) begin
          hold_req = 1'b1;
          for (int i = 0; i < 24; i++) add_char(8'($urandom_range(255)));
          close_text();
        end else begin
          build_string($urandom_range(10, 1));
        end
        if (p == 4 && phase_items == 0) pause_at = text.size() / 2;
        phase_items += text.size();
        send_text(pause_at);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d source characters in %0d strings, %0d results, %0d overflow ends",
             sb.inputs_seen, sb.strings_done, sb.results_seen, sb.overflow_ends);
    $display("capacity written %0d times under three stall patterns and a long output hold-off",
             settings_used);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_json_string_unescape_unit: PASS");
    else
      $display("tb_json_string_unescape_unit: FAIL");
    $finish;
  end

endmodule
